// ===== rtl/mffd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mffd_pkg
// Shared constants and controller/datapath interface types for the servo
// feedback frame decoder.
// ----------------------------------------------------------------------------
package mffd_pkg;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_ID  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_REVERSE   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RECIP     = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_AUTO_ZERO = 2'd3;

	localparam logic [7:0]  MOTOR_ID_RST = 8'd1;
	localparam logic [19:0] RECIP_RST    = 20'd65536;

	localparam logic [4:0] FEEDBACK_TYPE = 5'd2;
	localparam logic [3:0] MIN_LENGTH    = 4'd8;

	localparam logic signed [17:0] HALF_COUNTS = 18'sd65535;

	localparam logic signed [15:0] TURN_MAX = 16'sh7fff;
	localparam logic signed [15:0] TURN_MIN = 16'sh8000;

	localparam int FRAME_CNT_W = 6;
	localparam logic [FRAME_CNT_W-1:0] AUTO_ZERO_FRAME = 6'd50;
	localparam logic [FRAME_CNT_W-1:0] FRAME_CNT_MAX   = AUTO_ZERO_FRAME + 6'd1;

	localparam int OUT_W = 41;

	typedef struct packed {
		logic load;
		logic do_unwrap;
		logic do_mul;
		logic do_out;
	} mffd_cmd_t;

	typedef struct packed {
		logic frame_ok;
	} mffd_sts_t;

endpackage
`default_nettype wire

// ===== rtl/mffd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mffd_ctrl
// Sequencer: accepts a frame, steps the datapath through unwrap, multiply
// and output, and owns the output valid flag.
// ----------------------------------------------------------------------------
module mffd_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire                       out_ready,
	input  wire mffd_pkg::mffd_sts_t  sts,
	output mffd_pkg::mffd_cmd_t       cmd
);
	import mffd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UNWRAP,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.do_unwrap = (state_q == ST_UNWRAP);
		cmd.do_mul    = (state_q == ST_MUL);
		// output register must be free or draining this cycle
		cmd.do_out    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load && sts.frame_ok)
						state_q <= ST_UNWRAP;
				end
				ST_UNWRAP: state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_FIN;
				ST_FIN: begin
					if (cmd.do_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mffd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mffd_datapath
// Config registers, frame filter, field extraction, multi-turn unwrap,
// Q4.16 reduction scaling and the output register.
// ----------------------------------------------------------------------------
module mffd_datapath (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [mffd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire  [mffd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire  [28:0]                        frame_id,
	input  wire                                is_extended,
	input  wire  [3:0]                         length,
	input  wire  [63:0]                        payload,
	input  wire mffd_pkg::mffd_cmd_t           cmd,
	output mffd_pkg::mffd_sts_t                sts,
	output logic [5:0]                         fault_bits,
	output logic [1:0]                         run_mode,
	output logic signed [16:0]                 angle_half,
	output logic signed [16:0]                 velocity_half,
	output logic signed [16:0]                 torque_half,
	output logic [15:0]                        temperature_tenths,
	output logic signed [15:0]                 turn_count,
	output logic signed [mffd_pkg::OUT_W-1:0]  output_angle,
	output logic signed [mffd_pkg::OUT_W-1:0]  output_velocity
);
	import mffd_pkg::*;

	// configuration
	logic [7:0]  motor_id_q;
	logic        reverse_q;
	logic [19:0] recip_q;
	logic        auto_zero_q;

	// tracking state
	logic signed [16:0]      last_angle_q;
	logic signed [15:0]      turns_q;
	logic signed [16:0]      zero_point_q;
	logic [FRAME_CNT_W-1:0]  frames_q;

	// captured frame fields
	logic [5:0]         fault_q;
	logic [1:0]         run_q;
	logic signed [16:0] ang_q;
	logic signed [16:0] vel_q;
	logic signed [16:0] tor_q;
	logic [15:0]        temp_q;

	// stage 1: unwrap and magnitudes
	logic [32:0]        s_mag_s1;
	logic               s_neg_s1;
	logic [15:0]        v_mag_s1;
	logic               v_neg_s1;
	logic               zero_hit_s1;
	logic signed [15:0] turns_s1;

	// stage 2: products
	logic [52:0] prod_a_s2;
	logic [35:0] prod_v_s2;

	logic signed [17:0] ang_w, vel_w, tor_w;
	logic signed [17:0] d_w;
	logic signed [15:0] turns_new;
	logic [FRAME_CNT_W-1:0] frames_new;
	logic               zero_hit;
	logic signed [34:0] t_ext, s_w;
	logic signed [16:0] v_abs;
	logic [52:0]        round_a;
	logic [35:0]        round_v;
	logic signed [OUT_W-1:0] oa_mag, ov_mag;

	assign sts.frame_ok = is_extended && (length >= MIN_LENGTH)
		&& (frame_id[15:8] == motor_id_q) && (frame_id[28:24] == FEEDBACK_TYPE);

	assign ang_w = $signed({1'b0, payload[63:48], 1'b0}) - HALF_COUNTS;
	assign vel_w = $signed({1'b0, payload[47:32], 1'b0}) - HALF_COUNTS;
	assign tor_w = $signed({1'b0, payload[31:16], 1'b0}) - HALF_COUNTS;

	// unwrap
	always_comb begin
		d_w = {ang_q[16], ang_q} - {last_angle_q[16], last_angle_q};
		turns_new = turns_q;
		if (d_w < -HALF_COUNTS) begin
			if (turns_q != TURN_MAX)
				turns_new = turns_q + 16'sd1;
		end else if (d_w > HALF_COUNTS) begin
			if (turns_q != TURN_MIN)
				turns_new = turns_q - 16'sd1;
		end
		frames_new = (frames_q < FRAME_CNT_MAX) ? frames_q + 6'd1 : frames_q;
		zero_hit   = auto_zero_q && (frames_new == AUTO_ZERO_FRAME);
		// turns * 131070 as turns*2^17 - turns*2
		t_ext = {{19{turns_new[15]}}, turns_new};
		s_w   = (t_ext <<< 17) - (t_ext <<< 1)
			+ {{18{ang_q[16]}}, ang_q} - {{18{zero_point_q[16]}}, zero_point_q};
		v_abs = vel_q[16] ? -vel_q : vel_q;
	end

	// round half away from zero on the magnitude, then restore the sign
	always_comb begin
		round_a = (prod_a_s2 + 53'd32768) >> 16;
		round_v = (prod_v_s2 + 36'd32768) >> 16;
		oa_mag  = $signed({4'b0, round_a[36:0]});
		ov_mag  = $signed({21'b0, round_v[19:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_id_q   <= MOTOR_ID_RST;
			reverse_q    <= 1'b0;
			recip_q      <= RECIP_RST;
			auto_zero_q  <= 1'b0;
			last_angle_q <= '0;
			turns_q      <= '0;
			zero_point_q <= '0;
			frames_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_MOTOR_ID:  motor_id_q  <= cfg_wdata[7:0];
					REG_REVERSE:   reverse_q   <= cfg_wdata[0];
					REG_RECIP:     recip_q     <= cfg_wdata;
					REG_AUTO_ZERO: auto_zero_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.do_unwrap) begin
				last_angle_q <= ang_q;
				frames_q     <= frames_new;
				turns_q      <= zero_hit ? '0 : turns_new;
				if (zero_hit)
					zero_point_q <= ang_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fault_q <= frame_id[21:16];
			run_q   <= frame_id[23:22];
			ang_q   <= $signed(ang_w[16:0]);
			vel_q   <= $signed(vel_w[16:0]);
			tor_q   <= $signed(tor_w[16:0]);
			temp_q  <= payload[15:0];
		end
		if (cmd.do_unwrap) begin
			s_neg_s1    <= s_w[34];
			s_mag_s1    <= s_w[34] ? 33'(-s_w) : s_w[32:0];
			v_neg_s1    <= vel_q[16];
			v_mag_s1    <= v_abs[15:0];
			zero_hit_s1 <= zero_hit;
			turns_s1    <= zero_hit ? '0 : turns_new;
		end
		if (cmd.do_mul) begin
			prod_a_s2 <= 53'(s_mag_s1) * 53'(recip_q);
			prod_v_s2 <= 36'(v_mag_s1) * 36'(recip_q);
		end
		if (cmd.do_out) begin
			fault_bits         <= fault_q;
			run_mode           <= run_q;
			angle_half         <= ang_q;
			velocity_half      <= vel_q;
			torque_half        <= tor_q;
			temperature_tenths <= temp_q;
			turn_count         <= turns_s1;
			if (zero_hit_s1)
				output_angle <= '0;
			else
				output_angle <= (s_neg_s1 != reverse_q) ? -oa_mag : oa_mag;
			output_velocity <= (v_neg_s1 != reverse_q) ? -ov_mag : ov_mag;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/motor_feedback_frame_decoder.sv =====
`default_nettype none
// out_valid rises after the input transaction has passed the unwrap, multiply and output states in order.
// The sequencer walks one frame at a time through the shared unwrap and multiply stages, so it takes
// no new frame until the last has left its output step; a rejected frame is dropped on acceptance.
// A waiting result stalls the sequencer only at its output step.
// Reset: asynchronous active low; config returns to defaults, turn/zero state clears.
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder
// Filters servo feedback CAN frames, decodes fields, unwraps position into a
// multi-turn angle and scales angle and velocity by the reduction reciprocal.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [mffd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire  [mffd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [28:0]                        frame_id,
	input  wire                                is_extended,
	input  wire  [3:0]                         length,
	input  wire  [63:0]                        payload,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [5:0]                         fault_bits,
	output logic [1:0]                         run_mode,
	output logic signed [16:0]                 angle_half,
	output logic signed [16:0]                 velocity_half,
	output logic signed [16:0]                 torque_half,
	output logic [15:0]                        temperature_tenths,
	output logic signed [15:0]                 turn_count,
	output logic signed [mffd_pkg::OUT_W-1:0]  output_angle,
	output logic signed [mffd_pkg::OUT_W-1:0]  output_velocity
);
	import mffd_pkg::*;

	mffd_cmd_t cmd;
	mffd_sts_t sts;

	mffd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mffd_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_addr           (cfg_addr),
		.cfg_wdata          (cfg_wdata),
		.frame_id           (frame_id),
		.is_extended        (is_extended),
		.length             (length),
		.payload            (payload),
		.cmd                (cmd),
		.sts                (sts),
		.fault_bits         (fault_bits),
		.run_mode           (run_mode),
		.angle_half         (angle_half),
		.velocity_half      (velocity_half),
		.torque_half        (torque_half),
		.temperature_tenths (temperature_tenths),
		.turn_count         (turn_count),
		.output_angle       (output_angle),
		.output_velocity    (output_velocity)
	);

`ifndef SYNTH
	// a rejected frame never starts the sequence
	a_reject_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !sts.frame_ok) |=> !cmd.do_unwrap)
		else $error("rejected frame started unwrap");

	a_unwrap_then_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_unwrap |=> cmd.do_mul)
		else $error("multiply did not follow unwrap");

	// output register is never overwritten while a result is stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_out |-> !(out_valid && !out_ready))
		else $error("pending result overwritten");

	a_out_presented: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_out |=> out_valid)
		else $error("result not presented after output load");
`endif

endmodule
`default_nettype wire
